### design/irm_pkg.sv
// Shared constants and types for the interval range map.
`timescale 1ns / 1ps

package irm_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int KEY_BITS_DEF   = 16;
  localparam int VALUE_BITS_DEF = 8;

  localparam logic CMD_ASSIGN = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHR,
    CELL_SHL,
    CELL_WRITE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       wr_lo_en;
    logic       wr_hi_en;
  } cell_ctl_t;

endpackage

### design/irm_cell.sv
// One breakpoint cell: holds a key and value, compares, shifts to its neighbors.
`timescale 1ns / 1ps

module irm_cell import irm_pkg::*; #(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int CNT_W      = 6,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [CNT_W-1:0]      count,
  input  logic [CNT_W-1:0]      seg,
  input  logic [CNT_W-1:0]      wr_lo_pos,
  input  logic [CNT_W-1:0]      wr_hi_pos,
  input  logic [KEY_BITS-1:0]   cmp_lo,
  input  logic [KEY_BITS-1:0]   cmp_hi,
  input  logic [KEY_BITS-1:0]   wr_lo_key,
  input  logic [VALUE_BITS-1:0] wr_lo_val,
  input  logic [KEY_BITS-1:0]   wr_hi_key,
  input  logic [VALUE_BITS-1:0] wr_hi_val,
  input  logic [KEY_BITS-1:0]   left_key,
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic [KEY_BITS-1:0]   right_key,
  input  logic [VALUE_BITS-1:0] right_val,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] val,
  output logic                  lt,
  output logic                  le
);

  localparam logic [CNT_W:0] IDX = (CNT_W+1)'(INDEX);

  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  used;
  logic                  take_left;
  logic                  take_right;

  assign used       = IDX < {1'b0, count};
  assign take_left  = IDX >= ({1'b0, seg} + 1'b1);
  assign take_right = (IDX + 1'b1) >= {1'b0, seg};

  assign lt  = used && (key_r < cmp_lo);
  assign le  = used && (key_r <= cmp_hi);
  assign key = key_r;
  assign val = val_r;

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    unique case (ctl.mode)
      CELL_HOLD: begin
      end
      CELL_SHR: begin
        if (take_left) begin
          key_nxt = left_key;
          val_nxt = left_val;
        end
      end
      CELL_SHL: begin
        if (take_right) begin
          key_nxt = right_key;
          val_nxt = right_val;
        end
      end
      CELL_WRITE: begin
        if (ctl.wr_lo_en && IDX == {1'b0, wr_lo_pos}) begin
          key_nxt = wr_lo_key;
          val_nxt = wr_lo_val;
        end else if (ctl.wr_hi_en && IDX == {1'b0, wr_hi_pos}) begin
          key_nxt = wr_hi_key;
          val_nxt = wr_hi_val;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

endmodule

### design/interval_range_map.sv
// Interval range map: top level with sequencer and row of breakpoint cells.
//
// Input channel (in_valid / in_stall): one command per transfer. An assign
// sets [in_key_low, in_key_high) to in_new_value; a lookup returns the value
// at in_key_low. Each command gives exactly one result transfer on the
// output channel (out_valid / out_stall) with read value, status and the
// number of breakpoints held afterwards.
// Config channel (cfg_valid / cfg_ready): writes the default value of keys
// below the first breakpoint; cfg_ready is always high. Write only while idle.
// Sequencing: one command at a time. A lookup or a rejected assign is compared,
// then decided, and its result is loaded into the output register; the
// sequencer then returns to idle and the next command can be taken.
// A successful assign is compared and decided, then the upper part of the
// table moves to its new place, the cells moving entries one position per
// cycle, and then the new entries are written and the result is loaded.
// A result waiting in the output register does not block the next command;
// if the receiver stalls and a second result is ready, the sequencer holds
// until the output register frees up.
// Reset: the table is empty, the default value is zero, no result is pending.
`timescale 1ns / 1ps

module interval_range_map import irm_pkg::*; #(
  parameter  int CAPACITY   = CAPACITY_DEF,
  parameter  int KEY_BITS   = KEY_BITS_DEF,
  parameter  int VALUE_BITS = VALUE_BITS_DEF,
  localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic [KEY_BITS-1:0]   in_key_low,
  input  logic [KEY_BITS-1:0]   in_key_high,
  input  logic [VALUE_BITS-1:0] in_new_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_read_value,
  output logic [1:0]            out_status,
  output logic [CNT_W-1:0]      out_entries_used,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [VALUE_BITS-1:0] cfg_default_value
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_DEC   = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  localparam logic [CNT_W:0] CAP_W = (CNT_W+1)'(CAPACITY);

  logic [1:0]            state_r;
  logic [CNT_W-1:0]      count_r;
  logic [VALUE_BITS-1:0] default_r;

  logic                  cmd_r;
  logic [KEY_BITS-1:0]   key_lo_r;
  logic [KEY_BITS-1:0]   key_hi_r;
  logic [VALUE_BITS-1:0] new_r;

  logic [CNT_W-1:0]      below_r;
  logic [CNT_W-1:0]      above_r;
  logic [VALUE_BITS-1:0] prev_r;
  logic [VALUE_BITS-1:0] oldh_r;
  logic                  ins_lo_r;
  logic                  ins_hi_r;
  logic [CNT_W-1:0]      total_r;
  logic [CNT_W-1:0]      tgt_r;
  logic [CNT_W-1:0]      seg_r;

  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_read_r;
  logic [1:0]            out_status_r;
  logic [CNT_W-1:0]      out_used_r;

  logic [KEY_BITS-1:0]   key_w  [CAPACITY];
  logic [VALUE_BITS-1:0] val_w  [CAPACITY];
  logic [KEY_BITS-1:0]   lkey_w [CAPACITY];
  logic [VALUE_BITS-1:0] lval_w [CAPACITY];
  logic [KEY_BITS-1:0]   rkey_w [CAPACITY];
  logic [VALUE_BITS-1:0] rval_w [CAPACITY];
  logic [CAPACITY:0]     lt_v;
  logic [CAPACITY:0]     le_v;

  logic [CNT_W-1:0]      below_c;
  logic [CNT_W-1:0]      above_c;
  logic [VALUE_BITS-1:0] prev_or;
  logic [VALUE_BITS-1:0] oldh_or;
  logic [KEY_BITS-1:0]   cmp_hi;

  logic                  ins_lo_c;
  logic                  ins_hi_c;
  logic [CNT_W:0]        tgt_c;
  logic [CNT_W:0]        total_c;
  logic                  out_free;
  logic                  accept;
  cell_ctl_t             ctl;
  logic                  out_load;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // a new result enters the output register this cycle
  assign out_load = out_free &&
      ((state_r == S_DEC &&
        (cmd_r == CMD_LOOKUP || !(key_lo_r < key_hi_r) || total_c > CAP_W)) ||
       (state_r == S_SHIFT && seg_r == tgt_r));

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_read_r;
  assign out_status       = out_status_r;
  assign out_entries_used = out_used_r;

  // a lookup compares against its key on the upper comparator
  assign cmp_hi = (cmd_r == CMD_LOOKUP) ? key_lo_r : key_hi_r;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_lend
      assign lkey_w[i] = key_w[i];
      assign lval_w[i] = val_w[i];
    end else begin : g_lmid
      assign lkey_w[i] = key_w[i-1];
      assign lval_w[i] = val_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_rend
      assign rkey_w[i] = key_w[i];
      assign rval_w[i] = val_w[i];
    end else begin : g_rmid
      assign rkey_w[i] = key_w[i+1];
      assign rval_w[i] = val_w[i+1];
    end

    irm_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS),
      .CNT_W     (CNT_W),
      .INDEX     (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count_r),
      .seg      (seg_r),
      .wr_lo_pos(below_r),
      .wr_hi_pos(below_r + CNT_W'(ins_lo_r)),
      .cmp_lo   (key_lo_r),
      .cmp_hi   (cmp_hi),
      .wr_lo_key(key_lo_r),
      .wr_lo_val(new_r),
      .wr_hi_key(key_hi_r),
      .wr_hi_val(oldh_r),
      .left_key (lkey_w[i]),
      .left_val (lval_w[i]),
      .right_key(rkey_w[i]),
      .right_val(rval_w[i]),
      .key      (key_w[i]),
      .val      (val_w[i]),
      .lt       (lt_v[i]),
      .le       (le_v[i])
    );
  end

  assign lt_v[CAPACITY] = 1'b0;
  assign le_v[CAPACITY] = 1'b0;

  // compare flags are thermometer codes; pick the cell at each edge
  always_comb begin
    below_c = '0;
    above_c = '0;
    prev_or = '0;
    oldh_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lt_v[i] && !lt_v[i+1]) begin
        below_c = below_c | CNT_W'(i + 1);
        prev_or = prev_or | val_w[i];
      end
      if (le_v[i] && !le_v[i+1]) begin
        above_c = above_c | CNT_W'(i + 1);
        oldh_or = oldh_or | val_w[i];
      end
    end
  end

  assign ins_lo_c = new_r != prev_r;
  assign ins_hi_c = oldh_r != new_r;
  assign tgt_c    = {1'b0, below_r} + (CNT_W+1)'(ins_lo_c) + (CNT_W+1)'(ins_hi_c);
  assign total_c  = tgt_c + ({1'b0, count_r} - {1'b0, above_r});

  always_comb begin
    ctl.mode     = CELL_HOLD;
    ctl.wr_lo_en = ins_lo_r;
    ctl.wr_hi_en = ins_hi_r;
    if (state_r == S_SHIFT) begin
      if (seg_r < tgt_r) begin
        ctl.mode = CELL_SHR;
      end else if (seg_r > tgt_r) begin
        ctl.mode = CELL_SHL;
      end else if (out_free) begin
        ctl.mode = CELL_WRITE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      default_r <= cfg_default_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_command;
      key_lo_r <= in_key_low;
      key_hi_r <= in_key_high;
      new_r    <= in_new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          below_r <= below_c;
          above_r <= above_c;
          prev_r  <= (below_c == '0) ? default_r : prev_or;
          oldh_r  <= (above_c == '0) ? default_r : oldh_or;
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (cmd_r == CMD_LOOKUP) begin
            if (out_free) begin
              out_valid_r  <= 1'b1;
              out_read_r   <= oldh_r;
              out_status_r <= ST_DONE;
              out_used_r   <= count_r;
              state_r      <= S_IDLE;
            end
          end else if (!(key_lo_r < key_hi_r)) begin
            if (out_free) begin
              out_valid_r  <= 1'b1;
              out_read_r   <= '0;
              out_status_r <= ST_EMPTY;
              out_used_r   <= count_r;
              state_r      <= S_IDLE;
            end
          end else if (total_c > CAP_W) begin
            if (out_free) begin
              out_valid_r  <= 1'b1;
              out_read_r   <= '0;
              out_status_r <= ST_OVERFLOW;
              out_used_r   <= count_r;
              state_r      <= S_IDLE;
            end
          end else begin
            ins_lo_r <= ins_lo_c;
            ins_hi_r <= ins_hi_c;
            tgt_r    <= tgt_c[CNT_W-1:0];
            total_r  <= total_c[CNT_W-1:0];
            seg_r    <= above_r;
            state_r  <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // move the upper segment one place per cycle, then drop in new entries
          if (seg_r < tgt_r) begin
            seg_r <= seg_r + 1'b1;
          end else if (seg_r > tgt_r) begin
            seg_r <= seg_r - 1'b1;
          end else if (out_free) begin
            count_r      <= total_r;
            out_valid_r  <= 1'b1;
            out_read_r   <= '0;
            out_status_r <= ST_DONE;
            out_used_r   <= total_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/irm_checker.sv
// Port-level checks for the interval range map, bound to the top level.
`timescale 1ns / 1ps

module irm_checker import irm_pkg::*; #(
  parameter  int CAPACITY   = CAPACITY_DEF,
  parameter  int VALUE_BITS = VALUE_BITS_DEF,
  localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [VALUE_BITS-1:0] out_read_value,
  input logic [1:0]            out_status,
  input logic [CNT_W-1:0]      out_entries_used
);

  localparam logic [CNT_W:0] CAP_W = (CNT_W+1)'(CAPACITY);

  // one command at a time: a transfer makes the block busy next cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous command still in work");

  a_used_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_entries_used} <= CAP_W)
    else $error("entries used beyond capacity");

  a_read_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_value != '0 |-> out_status == ST_DONE)
    else $error("nonzero read value with non-done status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value)
      && $stable(out_status) && $stable(out_entries_used))
    else $error("stalled result changed");

endmodule

bind interval_range_map irm_checker #(
  .CAPACITY  (CAPACITY),
  .VALUE_BITS(VALUE_BITS)
) u_irm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_read_value  (out_read_value),
  .out_status      (out_status),
  .out_entries_used(out_entries_used)
);

### test/interval_range_map_check.sv
// Checker for the interval range map: predicts each result and compares it.
`timescale 1ns / 1ps

module interval_range_map_check import irm_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_command,
  input  logic [KEY_BITS-1:0]   in_key_low,
  input  logic [KEY_BITS-1:0]   in_key_high,
  input  logic [VALUE_BITS-1:0] in_new_value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [VALUE_BITS-1:0] out_read_value,
  input  logic [1:0]            out_status,
  input  logic [CNT_W-1:0]      out_entries_used,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [VALUE_BITS-1:0] cfg_default_value,
  output int                    mismatch_count,
  output int                    results_pending
);

  typedef struct {
    logic [VALUE_BITS-1:0] read_value;
    logic [1:0]            status;
    logic [CNT_W-1:0]      entries_used;
  } map_result_t;

  // Predicted breakpoint table
  logic [KEY_BITS-1:0]   bp_key [CAPACITY];
  logic [VALUE_BITS-1:0] bp_val [CAPACITY];
  int                    bp_count;
  logic [VALUE_BITS-1:0] base_value;

  map_result_t pending_results [$];
  map_result_t predicted;
  map_result_t observed;
  logic [1:0]  assign_status;

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  // Table is sorted, so the last breakpoint at or below the key wins.
  function automatic logic [VALUE_BITS-1:0] map_value_at(input logic [KEY_BITS-1:0] key);
    logic [VALUE_BITS-1:0] v;
    v = base_value;
    for (int i = 0; i < bp_count; i++) begin
      if (bp_key[i] <= key) v = bp_val[i];
    end
    return v;
  endfunction

  task automatic apply_range(input logic [KEY_BITS-1:0] lo, input logic [KEY_BITS-1:0] hi,
                             input logic [VALUE_BITS-1:0] val, output logic [1:0] st);
    int                    below;
    int                    above_start;
    int                    total;
    int                    n;
    logic [VALUE_BITS-1:0] prev_low;
    logic [VALUE_BITS-1:0] old_high;
    bit                    ins_low;
    bit                    ins_high;
    logic [KEY_BITS-1:0]   nk [CAPACITY];
    logic [VALUE_BITS-1:0] nv [CAPACITY];
    if (lo >= hi) begin
      st = ST_EMPTY;
    end else begin
      below = 0;
      while (below < bp_count && bp_key[below] < lo) below++;
      above_start = below;
      while (above_start < bp_count && bp_key[above_start] <= hi) above_start++;
      prev_low = (below > 0) ? bp_val[below-1] : base_value;
      old_high = map_value_at(hi);
      ins_low  = (val != prev_low);
      ins_high = (old_high != val);
      total = below + int'(ins_low) + int'(ins_high) + (bp_count - above_start);
      if (total > CAPACITY) begin
        st = ST_OVERFLOW;
      end else begin
        n = 0;
        for (int i = 0; i < below; i++) begin
          nk[n] = bp_key[i];
          nv[n] = bp_val[i];
          n++;
        end
        if (ins_low) begin
          nk[n] = lo;
          nv[n] = val;
          n++;
        end
        if (ins_high) begin
          nk[n] = hi;
          nv[n] = old_high;
          n++;
        end
        for (int i = above_start; i < bp_count; i++) begin
          nk[n] = bp_key[i];
          nv[n] = bp_val[i];
          n++;
        end
        for (int i = 0; i < n; i++) begin
          bp_key[i] = nk[i];
          bp_val[i] = nv[i];
        end
        bp_count = n;
        st = ST_DONE;
      end
    end
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bp_count   = 0;
      base_value = '0;
      pending_results.delete();
      results_pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) base_value = cfg_default_value;

      // Retire the oldest expectation before queuing a new one.
      if (out_valid && !out_stall) begin
        observed.read_value   = out_read_value;
        observed.status       = out_status;
        observed.entries_used = out_entries_used;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing pending: read_value %0d status %0d entries %0d",
                 out_read_value, out_status, out_entries_used);
          mismatch_count++;
        end else begin
          predicted = pending_results.pop_front();
          report_field("read_value", 32'(predicted.read_value), 32'(observed.read_value));
          report_field("status", 32'(predicted.status), 32'(observed.status));
          report_field("entries_used", 32'(predicted.entries_used),
                       32'(observed.entries_used));
        end
      end

      if (in_valid && !in_stall) begin
        predicted.read_value = '0;
        predicted.status     = ST_DONE;
        if (in_command == CMD_LOOKUP) begin
          predicted.read_value = map_value_at(in_key_low);
        end else begin
          apply_range(in_key_low, in_key_high, in_new_value, assign_status);
          predicted.status = assign_status;
        end
        predicted.entries_used = CNT_W'(bp_count);
        pending_results.push_back(predicted);
      end

      results_pending <= pending_results.size();
    end
  end

endmodule

### test/interval_range_map_tb.sv
// Testbench top for the interval range map: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module interval_range_map_tb;
  import irm_pkg::*;

  localparam int CAPACITY      = CAPACITY_DEF;
  localparam int KEY_BITS      = KEY_BITS_DEF;
  localparam int VALUE_BITS    = VALUE_BITS_DEF;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 250;
  localparam int WINDOW_TOP    = 65535 - 128;

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  in_valid          = 1'b0;
  logic                  in_command        = CMD_ASSIGN;
  logic [KEY_BITS-1:0]   in_key_low        = '0;
  logic [KEY_BITS-1:0]   in_key_high       = '0;
  logic [VALUE_BITS-1:0] in_new_value      = '0;
  logic                  out_stall         = 1'b0;
  logic                  cfg_valid         = 1'b0;
  logic [VALUE_BITS-1:0] cfg_default_value = '0;

  logic                  in_stall;
  logic                  out_valid;
  logic [VALUE_BITS-1:0] out_read_value;
  logic [1:0]            out_status;
  logic [CNT_W-1:0]      out_entries_used;
  logic                  cfg_ready;

  int mismatch_count;
  int results_pending;
  int send_idle_pct = 32;
  int recv_idle_pct = 73;

  always #4 clk = ~clk;

  interval_range_map #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_key_low       (in_key_low),
    .in_key_high      (in_key_high),
    .in_new_value     (in_new_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_value   (out_read_value),
    .out_status       (out_status),
    .out_entries_used (out_entries_used),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_default_value(cfg_default_value)
  );

  interval_range_map_check #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS),
    .CNT_W     (CNT_W)
  ) u_map_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_key_low       (in_key_low),
    .in_key_high      (in_key_high),
    .in_new_value     (in_new_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_value   (out_read_value),
    .out_status       (out_status),
    .out_entries_used (out_entries_used),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_default_value(cfg_default_value),
    .mismatch_count   (mismatch_count),
    .results_pending  (results_pending)
  );

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Hold the payload until the transfer happens.
  task automatic send_item(input logic cmd, input logic [KEY_BITS-1:0] lo,
                           input logic [KEY_BITS-1:0] hi, input logic [VALUE_BITS-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_key_low   <= lo;
    in_key_high  <= hi;
    in_new_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic write_default(input logic [VALUE_BITS-1:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_default_value <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly narrow assigns and lookups inside a small key window, so the table
  // fills, merges and overflows; the rest is full-range noise and empty ranges.
  task automatic random_item(input int key_base);
    int                    pick;
    logic [KEY_BITS-1:0]   a;
    logic [KEY_BITS-1:0]   b;
    logic [VALUE_BITS-1:0] v;
    pick = $urandom_range(0, 99);
    a    = KEY_BITS'(key_base + $urandom_range(0, 119));
    v    = ($urandom_range(0, 3) == 0) ? VALUE_BITS'($urandom) : VALUE_BITS'($urandom_range(0, 3));
    if (pick < 10) begin
      send_item(1'($urandom), KEY_BITS'($urandom), KEY_BITS'($urandom), VALUE_BITS'($urandom));
    end else if (pick < 18) begin
      b = KEY_BITS'($urandom_range(0, a));
      send_item(CMD_ASSIGN, a, b, v);
    end else if (pick < 20) begin
      send_item(CMD_ASSIGN, '0, '1, v);
    end else if (pick < 60) begin
      b = a + KEY_BITS'($urandom_range(1, 8));
      send_item(CMD_ASSIGN, a, b, v);
    end else begin
      a = KEY_BITS'(key_base + $urandom_range(0, 127));
      send_item(CMD_LOOKUP, a, KEY_BITS'($urandom), VALUE_BITS'($urandom));
    end
  endtask

  task automatic random_phase(input int key_base_lo, input int key_base_hi);
    int key_base;
    key_base = $urandom_range(key_base_lo, key_base_hi);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // Pause the sender until everything is back, now and then.
      if (i == PHASE_ITEMS / 2 || $urandom_range(0, 99) == 0) wait_drained();
      random_item(key_base);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, default value still at its reset value
    send_item(CMD_LOOKUP, '0, '1, '1);
    send_item(CMD_LOOKUP, '1, '0, '0);
    send_item(CMD_ASSIGN, 16'd5, 16'd5, 8'd9);
    send_item(CMD_ASSIGN, 16'd10, 16'd3, 8'd9);
    send_item(CMD_ASSIGN, '0, '1, '1);
    send_item(CMD_LOOKUP, 16'hFFFE, '0, '0);
    send_item(CMD_ASSIGN, 16'd100, 16'd200, '1);
    send_item(CMD_ASSIGN, 16'd100, 16'd200, 8'd7);
    send_item(CMD_ASSIGN, 16'd200, 16'd300, 8'd7);
    send_item(CMD_ASSIGN, '0, '1, '0);
    // Fill the table to capacity, then overflow it.
    for (int i = 0; i < CAPACITY / 2 + 1; i++) begin
      send_item(CMD_ASSIGN, KEY_BITS'(4 * i + 1), KEY_BITS'(4 * i + 3), VALUE_BITS'(i + 1));
    end
    send_item(CMD_LOOKUP, 16'd2, '0, '0);

    write_default('1);
    random_phase(0, 0);

    send_idle_pct = 73;
    recv_idle_pct = 32;
    write_default(VALUE_BITS'($urandom_range(1, 254)));
    random_phase(WINDOW_TOP, WINDOW_TOP);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_default('0);
    random_phase(0, WINDOW_TOP);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
